[hw/rtl/pfla_pkg.sv]
// Shared constants, codes and types of the page free-list allocator.
package pfla_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 3'd0,
        CMD_DISPOSE  = 3'd1,
        CMD_PAGE_AT  = 3'd2,
        CMD_FIRST    = 3'd3,
        CMD_LAST     = 3'd4,
        CMD_NEXT     = 3'd5,
        CMD_PREVIOUS = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_INVALID      = 3'd1,
        ST_ALREADY_FREE = 3'd2,
        ST_NOT_FOUND    = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] page;
    } t_res;

endpackage

[hw/rtl/pfla_if.sv]
// Command and response channel interfaces of the page free-list allocator.
interface pfla_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [pfla_pkg::CMD_W-1:0]  command;
    logic [pfla_pkg::PAGE_W-1:0] page_index;

    modport source (output valid, output command, output page_index, input ready);
    modport sink (input valid, input command, input page_index, output ready);
endinterface

interface pfla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pfla_pkg::STATUS_W-1:0] status;
    logic [pfla_pkg::PAGE_W-1:0]   result_page;

    modport source (output valid, output status, output result_page, input ready);
    modport sink (input valid, input status, input result_page, output ready);
endinterface

[hw/rtl/pfla_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module pfla_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pfla_ctrl.sv]
// Command sequencer: page count, free-list head, used-mark and link memories.
module pfla_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    pfla_cmd_if.sink              i_cmd,
    output logic                  o_res_valid,
    output pfla_pkg::t_res        o_res,
    input  logic                  i_res_ready
);

    localparam int AW = pfla_pkg::PAGE_W;
    localparam int CW = pfla_pkg::COUNT_W;

    pfla_pkg::t_state        r_state, n_state;
    logic [CW-1:0]           r_page_count, n_page_count;
    logic [AW-1:0]           r_free_head, n_free_head;
    logic                    r_free_empty, n_free_empty;
    logic                    r_file_open;
    logic [pfla_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [AW-1:0]           r_idx, n_idx;
    pfla_pkg::t_res          r_res, n_res;
    logic [CW-1:0]           r_scan_ptr, n_scan_ptr;
    logic [CW-1:0]           r_scan_left, n_scan_left;
    logic                    r_scan_down, n_scan_down;
    logic                    r_pend, n_pend;
    logic [AW-1:0]           r_rd_addr, n_rd_addr;

    logic                    used_we;
    logic [AW-1:0]           used_waddr;
    logic                    used_wdata;
    logic [AW-1:0]           used_raddr;
    logic                    used_rdata;
    logic                    link_we;
    logic [AW:0]             link_wdata;
    logic [AW:0]             link_rdata;

    logic                    page_ok;
    logic                    scan_go;
    logic [CW-1:0]           scan_lo;
    logic [CW-1:0]           scan_hi;
    logic                    scan_down;

    pfla_ram #(.DEPTH(pfla_pkg::MAX_PAGES), .WIDTH(1)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (used_raddr),
        .o_rdata (used_rdata)
    );

    pfla_ram #(.DEPTH(pfla_pkg::MAX_PAGES), .WIDTH(AW + 1)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_idx),
        .i_wdata (link_wdata),
        .i_raddr (r_free_head),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pfla_pkg::S_IDLE;
            r_page_count <= '0;
            r_free_head  <= '0;
            r_free_empty <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_page_count <= n_page_count;
            r_free_head  <= n_free_head;
            r_free_empty <= n_free_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_open <= 1'b1;
        end else if (i_cfg_we) begin
            r_file_open <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_res       <= n_res;
        r_scan_ptr  <= n_scan_ptr;
        r_scan_left <= n_scan_left;
        r_scan_down <= n_scan_down;
        r_pend      <= n_pend;
        r_rd_addr   <= n_rd_addr;
    end

    assign page_ok     = r_file_open && ({1'b0, r_idx} < r_page_count);
    assign i_cmd.ready = (r_state == pfla_pkg::S_IDLE);
    assign o_res_valid = (r_state == pfla_pkg::S_RESP);
    assign o_res       = r_res;
    assign link_wdata  = {r_free_empty, r_free_head};

    always_comb begin
        n_state      = r_state;
        n_page_count = r_page_count;
        n_free_head  = r_free_head;
        n_free_empty = r_free_empty;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_res        = r_res;
        n_scan_ptr   = r_scan_ptr;
        n_scan_left  = r_scan_left;
        n_scan_down  = r_scan_down;
        n_pend       = r_pend;
        n_rd_addr    = r_rd_addr;
        used_we      = 1'b0;
        used_waddr   = r_idx;
        used_wdata   = 1'b0;
        used_raddr   = i_cmd.page_index;
        link_we      = 1'b0;
        scan_go      = 1'b0;
        scan_lo      = '0;
        scan_hi      = r_page_count;
        scan_down    = 1'b0;

        unique case (r_state)
            pfla_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.command;
                    n_idx   = i_cmd.page_index;
                    n_state = pfla_pkg::S_EXEC;
                end
            end
            pfla_pkg::S_EXEC: begin
                n_state = pfla_pkg::S_RESP;
                n_res   = '{status: pfla_pkg::ST_INVALID, page: '0};
                case (pfla_pkg::t_cmd'(r_cmd))
                    pfla_pkg::CMD_ALLOC: begin
                        if (!r_free_empty) begin
                            n_free_head  = link_rdata[AW-1:0];
                            n_free_empty = link_rdata[AW];
                            used_we      = 1'b1;
                            used_waddr   = r_free_head;
                            used_wdata   = 1'b1;
                            n_res        = '{status: pfla_pkg::ST_OK, page: r_free_head};
                        end else if (r_page_count[CW-1]) begin
                            n_res = '{status: pfla_pkg::ST_FULL, page: '0};
                        end else begin
                            used_we      = 1'b1;
                            used_waddr   = r_page_count[AW-1:0];
                            used_wdata   = 1'b1;
                            n_page_count = r_page_count + CW'(1);
                            n_res        = '{status: pfla_pkg::ST_OK,
                                             page: r_page_count[AW-1:0]};
                        end
                    end
                    pfla_pkg::CMD_DISPOSE: begin
                        if (!page_ok) begin
                            n_res = '{status: pfla_pkg::ST_INVALID, page: '0};
                        end else if (!used_rdata) begin
                            n_res = '{status: pfla_pkg::ST_ALREADY_FREE, page: '0};
                        end else begin
                            link_we      = 1'b1;
                            used_we      = 1'b1;
                            used_wdata   = 1'b0;
                            n_free_head  = r_idx;
                            n_free_empty = 1'b0;
                            n_res        = '{status: pfla_pkg::ST_OK, page: r_idx};
                        end
                    end
                    pfla_pkg::CMD_PAGE_AT: begin
                        if (!page_ok) begin
                            n_res = '{status: pfla_pkg::ST_INVALID, page: '0};
                        end else if (used_rdata) begin
                            n_res = '{status: pfla_pkg::ST_OK, page: r_idx};
                        end else begin
                            n_res = '{status: pfla_pkg::ST_NOT_FOUND, page: '0};
                        end
                    end
                    pfla_pkg::CMD_FIRST: begin
                        scan_go = 1'b1;
                    end
                    pfla_pkg::CMD_LAST: begin
                        scan_go   = 1'b1;
                        scan_down = 1'b1;
                    end
                    pfla_pkg::CMD_NEXT: begin
                        if (page_ok) begin
                            scan_go = 1'b1;
                            scan_lo = {1'b0, r_idx} + CW'(1);
                        end
                    end
                    pfla_pkg::CMD_PREVIOUS: begin
                        if (page_ok || ({1'b0, r_idx} == r_page_count)) begin
                            scan_go   = 1'b1;
                            scan_hi   = {1'b0, r_idx};
                            scan_down = 1'b1;
                        end
                    end
                    default: begin
                        n_res = '{status: pfla_pkg::ST_INVALID, page: '0};
                    end
                endcase
                if (scan_go) begin
                    if (scan_lo >= scan_hi) begin
                        n_res = '{status: pfla_pkg::ST_NOT_FOUND, page: '0};
                    end else if (!r_file_open) begin
                        n_res = '{status: pfla_pkg::ST_INVALID, page: '0};
                    end else begin
                        n_state     = pfla_pkg::S_SCAN;
                        n_scan_ptr  = scan_down ? (scan_hi - CW'(1)) : scan_lo;
                        n_scan_left = scan_hi - scan_lo;
                        n_scan_down = scan_down;
                        n_pend      = 1'b0;
                    end
                end
            end
            pfla_pkg::S_SCAN: begin
                used_raddr = r_scan_ptr[AW-1:0];
                if (r_pend && used_rdata) begin
                    n_res   = '{status: pfla_pkg::ST_OK, page: r_rd_addr};
                    n_state = pfla_pkg::S_RESP;
                end else if (r_scan_left == '0) begin
                    n_res   = '{status: pfla_pkg::ST_NOT_FOUND, page: '0};
                    n_state = pfla_pkg::S_RESP;
                end else begin
                    n_rd_addr   = r_scan_ptr[AW-1:0];
                    n_pend      = 1'b1;
                    n_scan_ptr  = r_scan_down ? (r_scan_ptr - CW'(1))
                                              : (r_scan_ptr + CW'(1));
                    n_scan_left = r_scan_left - CW'(1);
                end
            end
            pfla_pkg::S_RESP: begin
                if (i_res_ready) begin
                    n_state = pfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfla_pkg::S_IDLE;
            end
        endcase
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_count <= CW'(pfla_pkg::MAX_PAGES))
        else $error("page count beyond limit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_page_count != $past(r_page_count)))
        |-> (r_page_count == $past(r_page_count) + CW'(1)))
        else $error("page count moved by other than one");

    a_list_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_free_empty))
        |-> ($past(r_state) == pfla_pkg::S_EXEC
             && $past(r_cmd) == pfla_pkg::CMD_DISPOSE))
        else $error("free list filled without a dispose");

    a_fail_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_res.status != pfla_pkg::ST_OK) |-> (r_res.page == '0))
        else $error("failed result carries a page");

endmodule

[hw/rtl/page_free_list_allocator_core.sv]
// Top level of the page free-list allocator: sequencer and output register.
// Allocate, dispose and page_at: EXEC, then RESP, then the output register.
// First, last, next and previous: EXEC, then SCAN probing pages in turn through the
// single read port of the used-mark memory, then RESP; a probe is issued every cycle.
// One item in flight; the next is taken only after its result is registered.
// Reset is synchronous; page memories are not cleared and need no clearing pass.
module page_free_list_allocator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    pfla_cmd_if.sink   i_cmd,
    pfla_rsp_if.source o_rsp
);

    logic           res_valid;
    logic           res_ready;
    pfla_pkg::t_res res;
    logic           r_out_valid;
    pfla_pkg::t_res r_out;

    pfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.result_page = r_out.page;

endmodule

[verif/page_free_list_allocator_core_tb.sv]
// Self-checking testbench of the page free-list allocator core: directed and random items.
module page_free_list_allocator_core_tb;
    import pfla_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT_ITEM  = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 380;
    localparam int CLOSED_ITEMS  = 60;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } t_rx_mode;

    class pfla_scoreboard;
        bit                open_flag;
        bit [COUNT_W-1:0]  pages_in_file;
        bit [PAGE_W-1:0]   chain_head;
        bit                chain_empty;
        bit                is_used [MAX_PAGES];
        bit [PAGE_W-1:0]   chain_next [MAX_PAGES];
        bit                chain_last [MAX_PAGES];
        t_res              pending_results [$];
        int                mismatches;
        int                items_taken;
        int                results_checked;
        int                status_seen [5];

        function new();
            open_flag     = 1'b1;
            pages_in_file = '0;
            chain_head    = '0;
            chain_empty   = 1'b1;
            foreach (is_used[p]) begin
                is_used[p]    = 1'b0;
                chain_next[p] = '0;
                chain_last[p] = 1'b0;
            end
            mismatches      = 0;
            items_taken     = 0;
            results_checked = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
        endfunction

        function bit in_file(int idx);
            return open_flag && idx < pages_in_file;
        endfunction

        function t_status scan_for_used(int lo, int hi, bit down, output bit [PAGE_W-1:0] hit);
            int p;
            hit = '0;
            if (lo >= hi) return ST_NOT_FOUND;
            if (!open_flag) return ST_INVALID;
            for (int k = 0; k < hi - lo; k++) begin
                p = down ? (hi - 1 - k) : (lo + k);
                if (p < MAX_PAGES && is_used[p]) begin
                    hit = p[PAGE_W-1:0];
                    return ST_OK;
                end
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] idx);
            t_status          st;
            bit [PAGE_W-1:0]  pg;
            t_res             res;
            int               ix;
            st = ST_INVALID;
            pg = '0;
            ix = int'(idx);
            case (cmd)
                CMD_ALLOC: begin
                    if (!chain_empty) begin
                        pg          = chain_head;
                        chain_head  = chain_next[pg];
                        chain_empty = chain_last[pg];
                        is_used[pg] = 1'b1;
                        st          = ST_OK;
                    end else if (pages_in_file >= MAX_PAGES) begin
                        st = ST_FULL;
                    end else begin
                        pg = pages_in_file[PAGE_W-1:0];
                        is_used[pages_in_file] = 1'b1;
                        pages_in_file++;
                        st = ST_OK;
                    end
                end
                CMD_DISPOSE: begin
                    if (!in_file(ix)) begin
                        st = ST_INVALID;
                    end else if (!is_used[ix]) begin
                        st = ST_ALREADY_FREE;
                    end else begin
                        chain_next[ix] = chain_head;
                        chain_last[ix] = chain_empty;
                        chain_head     = idx;
                        chain_empty    = 1'b0;
                        is_used[ix]    = 1'b0;
                        pg             = idx;
                        st             = ST_OK;
                    end
                end
                CMD_PAGE_AT: begin
                    if (!in_file(ix)) begin
                        st = ST_INVALID;
                    end else if (is_used[ix]) begin
                        pg = idx;
                        st = ST_OK;
                    end else begin
                        st = ST_NOT_FOUND;
                    end
                end
                CMD_FIRST: st = scan_for_used(0, pages_in_file, 1'b0, pg);
                CMD_LAST: st = scan_for_used(0, pages_in_file, 1'b1, pg);
                CMD_NEXT: begin
                    if (!in_file(ix)) st = ST_INVALID;
                    else st = scan_for_used(ix + 1, pages_in_file, 1'b0, pg);
                end
                CMD_PREVIOUS: begin
                    if (!in_file(ix) && ix != pages_in_file) st = ST_INVALID;
                    else st = scan_for_used(0, ix, 1'b1, pg);
                end
                default: st = ST_INVALID;
            endcase
            if (st != ST_OK) pg = '0;
            res.status = st;
            res.page   = pg;
            pending_results.push_back(res);
            items_taken++;
        endfunction

        function void check_response(logic [STATUS_W-1:0] st, logic [PAGE_W-1:0] pg);
            t_res want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d page %0d",
                         $time, st, pg);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (st !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
                mismatches++;
            end
            if (pg !== want.page) begin
                $display("%0t: page mismatch, expected %0d, actual %0d", $time, want.page, pg);
                mismatches++;
            end
            if (!$isunknown(st) && st <= ST_FULL) status_seen[st]++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    pfla_cmd_if cmd_ch ();
    pfla_rsp_if rsp_ch ();

    pfla_scoreboard sb = new();
    int burst_left = 0;

    page_free_list_allocator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_rsp       (rsp_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_response(rsp_ch.status, rsp_ch.result_page);
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
                sb.note_command(cmd_ch.command, cmd_ch.page_index);
            if (i_cfg_we === 1'b1)
                sb.open_flag = i_cfg_wdata;
        end
    end

    // Receiver: stall on a changing pattern, and hold off once for a long stretch.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       phase;
        bit       held;
        mode         = RX_ALWAYS;
        mode_left    = 0;
        phase        = 0;
        held         = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && sb.items_taken >= HOLD_AT_ITEM) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_ALWAYS: rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                    default:   rsp_ch.ready <= (phase % 4 != 0);
                endcase
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.page_index <= idx;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_file_open(input logic value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [PAGE_W-1:0] near_count(int n);
        int v;
        v = $urandom_range(0, n + 2);
        if (v > MAX_PAGES - 1) v = MAX_PAGES - 1;
        return v[PAGE_W-1:0];
    endfunction

    function automatic logic [PAGE_W-1:0] pick_used(int n);
        int p;
        p = 0;
        if (n == 0) return '0;
        for (int t = 0; t < 8; t++) begin
            p = $urandom_range(0, n - 1);
            if (sb.is_used[p]) return p[PAGE_W-1:0];
        end
        return p[PAGE_W-1:0];
    endfunction

    task automatic send_random_item();
        int                roll;
        int                n;
        logic [PAGE_W-1:0] idx;
        roll = $urandom_range(0, 99);
        n    = int'(sb.pages_in_file);
        idx  = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
        if (roll < 25)
            send_item(CMD_ALLOC, idx);
        else if (roll < 50)
            send_item(CMD_DISPOSE, ($urandom_range(0, 3) != 0) ? pick_used(n) : near_count(n));
        else if (roll < 62)
            send_item(CMD_PAGE_AT, ($urandom_range(0, 1) != 0) ? pick_used(n) : near_count(n));
        else if (roll < 70)
            send_item(CMD_FIRST, idx);
        else if (roll < 78)
            send_item(CMD_LAST, idx);
        else if (roll < 87)
            send_item(CMD_NEXT, ($urandom_range(0, 4) != 0) ? pick_used(n) : near_count(n));
        else if (roll < 96)
            send_item(CMD_PREVIOUS, ($urandom_range(0, 3) == 0 && n < MAX_PAGES)
                                    ? n[PAGE_W-1:0] : near_count(n));
        else if (roll < 98)
            send_item(CMD_UNUSED, idx);
        else
            send_item(CMD_W'($urandom_range(0, 7)), idx);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = '0;
        cmd_ch.page_index = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // closed file on an empty store: empty scans, invalid pages, unused code, an allocate
        set_file_open(1'b0);
        send_item(CMD_FIRST, '0);
        send_item(CMD_LAST, '0);
        send_item(CMD_PREVIOUS, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_DISPOSE, '0);
        send_item(CMD_PAGE_AT, PAGE_W'(MAX_PAGES - 1));
        send_item(CMD_UNUSED, '1);
        send_item(CMD_ALLOC, '1);
        set_file_open(1'b1);

        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_DISPOSE, 10'd1);
        send_item(CMD_DISPOSE, 10'd1);
        send_item(CMD_PAGE_AT, 10'd1);
        send_item(CMD_PAGE_AT, 10'd2);
        send_item(CMD_NEXT, 10'd0);
        send_item(CMD_PREVIOUS, 10'd4);
        send_item(CMD_PREVIOUS, 10'd1);
        send_item(CMD_FIRST, '0);
        send_item(CMD_LAST, '0);
        send_item(CMD_DISPOSE, 10'd3);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_NEXT, 10'd3);
        send_item(CMD_NEXT, PAGE_W'(MAX_PAGES - 1));

        for (int i = 0; i < RANDOM_ITEMS; i++) send_random_item();

        set_file_open(1'b0);
        for (int i = 0; i < CLOSED_ITEMS; i++) send_random_item();
        set_file_open(1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) send_random_item();

        set_file_open(1'b0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_PREVIOUS, PAGE_W'(MAX_PAGES - 1));
        send_item(CMD_LAST, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_DISPOSE, 10'd5);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items, %0d results: ok %0d, invalid %0d, free %0d, not found %0d, full %0d",
                 sb.items_taken, sb.results_checked, sb.status_seen[ST_OK],
                 sb.status_seen[ST_INVALID], sb.status_seen[ST_ALREADY_FREE],
                 sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL]);
        $display("file closed and reopened, a %0d-cycle result hold-off with the input stalled",
                 LONG_HOLD);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
